// ===== sv/tasr_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotator package
// Shared constants and types of the three-axis spin-ramp rotator.
// ----------------------------------------------------------------------------
package tasr_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ON     = 2'd1;
   localparam logic [1:0] OP_OFF    = 2'd2;
   localparam logic [1:0] OP_TOGGLE = 2'd3;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_UP   = 2'd1;
   localparam logic [1:0] MODE_RUN  = 2'd2;
   localparam logic [1:0] MODE_DOWN = 2'd3;

   localparam logic [2:0] CUE_NONE = 3'd0;
   localparam logic [2:0] CUE_BUSY = 3'd1;
   localparam logic [2:0] CUE_UP   = 3'd2;
   localparam logic [2:0] CUE_DOWN = 3'd3;
   localparam logic [2:0] CUE_STOP = 3'd4;

   localparam logic [2:0] REG_RATE_X = 3'd0;
   localparam logic [2:0] REG_RATE_Y = 3'd1;
   localparam logic [2:0] REG_RATE_Z = 3'd2;
   localparam logic [2:0] REG_UP_T   = 3'd3;
   localparam logic [2:0] REG_DOWN_T = 3'd4;

   // Divider request: magnitude of the 48-bit dividend and the 16-bit divisor.
   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/tasr_div.sv =====
// ----------------------------------------------------------------------------
// Rotator divider
// Restoring divider, one quotient bit per cycle, 48 by 16 bits unsigned.
// ----------------------------------------------------------------------------
module tasr_div import tasr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [47:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[47]};
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff;
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ===== sv/three_axis_spin_ramp_rotator.sv =====
// ----------------------------------------------------------------------------
// Three-axis spin-ramp rotator
// Ramped three-axis rotation driver with a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel (opcode, elapsed_ms) and each
// produces exactly one transfer on the rsp_ channel with the three angles,
// the mode after the item and a sound cue. Registers are written through the
// csr_ channel (index 0..4: rates x, y, z, spin-up and spin-down times); the
// user must write them only while the block is idle, which the block itself
// does not enforce; writes beyond the list are taken and dropped.
// A trigger item or a tick while off goes from idle straight to the finishing
// step. Any other tick takes each axis in turn through the axis step and the
// angle step; during a ramp, an axis that has finished its ramp needs only
// these, while for an axis still ramping the axis step forms the product
// rate * elapsed-ramp-time, the next step starts the shared restoring
// divider, the sequencer waits on it, and the angle step applies the sign
// and the angle update. req_ready is high only when no item is in work and
// no result waits, so the next input transfer comes at the earliest in the
// cycle after the result transfer. A stalled receiver simply holds the
// result in the output register. Reset clears the mode to off, all angles,
// velocities and ramp timers, and the registers to zero.
module three_axis_spin_ramp_rotator import tasr_pkg::*; #(
   parameter int ANGLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pitch_angle,
   output logic [31:0] rsp_yaw_angle,
   output logic [31:0] rsp_roll_angle,
   output logic [1:0]  rsp_run_mode,
   output logic [2:0]  rsp_sound_cue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AXIS = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_ANG  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [31:0] rate_ff [3];
   logic [47:0] up_t_ff, down_t_ff;
   logic [1:0]  mode_ff, mode_in;
   logic signed [17:0] left_ff [3];
   logic signed [32:0] vel_ff [3];
   logic [ANGLE_BITS-1:0] ang_ff [3];
   logic [1:0]  ax_ff, ax_in;
   logic [9:0]  el_ff;
   logic        ramp_ff, ramp_in;
   logic        done_ff, done_in;
   logic [2:0]  cue_ff, cue_in;
   logic        neg_ff;
   logic [47:0] prod_ff;
   logic        vld_ff;
   // Tracks whether the axis under work went through the divider.
   logic        div_used_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   tasr_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Per-axis views for the axis under work.
   logic signed [31:0] rate_c;
   logic [15:0] t_c;
   logic signed [17:0] left_c;
   logic signed [32:0] part_c;
   logic signed [32:0] vel_c;
   logic [31:0] rmag_c;
   logic signed [16:0] tdiff_c;
   logic [15:0] tmag_c;
   logic [47:0] upt_c, dnt_c;

   always_comb begin
      rate_c = signed'(rate_ff[ax_ff]);
      upt_c  = up_t_ff >> ({4'd0, ax_ff} * 6'd16);
      dnt_c  = down_t_ff >> ({4'd0, ax_ff} * 6'd16);
      t_c    = (mode_ff == MODE_UP) ? upt_c[15:0] : dnt_c[15:0];
      left_c = left_ff[ax_ff] - signed'({8'd0, el_ff});
      if (left_c < 0) left_c = -18'sd1;
      rmag_c  = rate_c[31] ? 32'(-rate_c) : 32'(rate_c);
      // The time left can exceed the ramp time when the times were rewritten
      // during a ramp, so the elapsed part of the ramp is signed.
      tdiff_c = signed'({1'b0, t_c}) - signed'({1'b0, left_c[15:0]});
      tmag_c  = tdiff_c[16] ? 16'(-tdiff_c) : tdiff_c[15:0];
      part_c  = neg_ff ? -signed'({1'b0, drsp.quotient[31:0]})
                       : signed'({1'b0, drsp.quotient[31:0]});
      vel_c   = (mode_ff == MODE_UP) ? part_c : (33'(rate_c) - part_c);
   end

   // New velocity of the axis under work: kept outside a ramp, from the quotient
   // while ramping, else finished: rate after spin up, zero after spin down.
   function automatic logic signed [32:0] vel_pick(input logic used,
      input logic ramp, input logic [1:0] m, input logic signed [32:0] vq,
      input logic signed [31:0] r, input logic signed [32:0] vs);
      if (!ramp) return vs;
      if (used) return vq;
      return (m == MODE_UP) ? 33'(r) : 33'sd0;
   endfunction

   function automatic logic signed [32:0] vel_in_axis();
      return vel_pick(div_used_ff, ramp_ff, mode_ff, vel_c, rate_c, vel_ff[ax_ff]);
   endfunction

   assign req_ready = (st_ff == ST_IDLE) && !vld_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      st_in   = st_ff;
      mode_in = mode_ff;
      ax_in   = ax_ff;
      ramp_in = ramp_ff;
      done_in = done_ff;
      cue_in  = cue_ff;
      dreq.start    = 1'b0;
      dreq.dividend = prod_ff;
      dreq.divisor  = t_c;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cue_in = CUE_NONE;
               ax_in  = 2'd0;
               done_in = 1'b1;
               ramp_in = (mode_ff == MODE_UP) || (mode_ff == MODE_DOWN);
               if (req_opcode != OP_TICK) begin
                  st_in = ST_FIN;
                  if (mode_ff == MODE_OFF && req_opcode != OP_OFF) begin
                     mode_in = MODE_UP;
                     cue_in  = CUE_UP;
                  end else if (mode_ff != MODE_OFF && req_opcode != OP_ON) begin
                     mode_in = MODE_DOWN;
                     cue_in  = CUE_DOWN;
                  end
               end else if (mode_ff == MODE_OFF) begin
                  st_in = ST_FIN;
               end else begin
                  st_in = ST_AXIS;
               end
            end
         end
         ST_AXIS: begin
            if (ramp_ff && rate_c != 0 && t_c != 16'd0 && !left_c[17]) begin
               st_in = ST_MUL;
            end else begin
               st_in = ST_ANG;
            end
         end
         ST_MUL: begin
            dreq.start = 1'b1;
            st_in = ST_DIV;
         end
         ST_DIV: begin
            if (drsp.done) st_in = ST_ANG;
         end
         ST_ANG: begin
            // An axis still ramping clears the all-done flag.
            if (ramp_ff && div_used_ff) done_in = 1'b0;
            if (ax_ff == 2'd2) begin
               st_in = ST_FIN;
               if (ramp_ff && done_in) begin
                  if (mode_ff == MODE_UP) begin
                     mode_in = MODE_RUN;
                     cue_in  = CUE_BUSY;
                  end else begin
                     mode_in = MODE_OFF;
                     cue_in  = CUE_STOP;
                  end
               end
            end else begin
               ax_in = ax_ff + 2'd1;
               st_in = ST_AXIS;
            end
         end
         ST_FIN: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         mode_ff   <= MODE_OFF;
         vld_ff    <= 1'b0;
         rate_ff   <= '{default: '0};
         up_t_ff   <= '0;
         down_t_ff <= '0;
         left_ff   <= '{default: '0};
         vel_ff    <= '{default: '0};
         ang_ff    <= '{default: '0};
         ax_ff     <= '0;
         ramp_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cue_ff    <= CUE_NONE;
      end else begin
         st_ff   <= st_in;
         mode_ff <= mode_in;
         ax_ff   <= ax_in;
         ramp_ff <= ramp_in;
         done_ff <= done_in;
         cue_ff  <= cue_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_RATE_X: rate_ff[0] <= csr_data[31:0];
               REG_RATE_Y: rate_ff[1] <= csr_data[31:0];
               REG_RATE_Z: rate_ff[2] <= csr_data[31:0];
               REG_UP_T:   up_t_ff    <= csr_data;
               REG_DOWN_T: down_t_ff  <= csr_data;
               default: ;
            endcase
         end
         // Triggers that start a ramp reload the timers with the full times.
         if (st_ff == ST_IDLE && req_valid && req_ready && req_opcode != OP_TICK) begin
            if (cue_in == CUE_UP) begin
               for (int i = 0; i < 3; i++) left_ff[i] <= 18'(up_t_ff[16*i +: 16]);
            end else if (cue_in == CUE_DOWN) begin
               for (int i = 0; i < 3; i++) left_ff[i] <= 18'(down_t_ff[16*i +: 16]);
            end
         end
         if (st_ff == ST_AXIS && ramp_ff) begin
            left_ff[ax_ff] <= left_c;
         end
         if (st_ff == ST_ANG) begin
            ang_ff[ax_ff] <= ang_ff[ax_ff]
               + ANGLE_BITS'(64'(signed'(vel_in_axis())) * 64'(el_ff));
            if (ramp_ff) vel_ff[ax_ff] <= vel_in_axis();
         end
         if (st_ff == ST_FIN) vld_ff <= 1'b1;
         else if (rsp_valid && rsp_ready) vld_ff <= 1'b0;
      end
      if (st_ff == ST_IDLE && req_valid && req_ready) el_ff <= req_elapsed_ms;
      if (st_ff == ST_AXIS) begin
         neg_ff  <= rate_c[31] ^ tdiff_c[16];
         prod_ff <= 48'(rmag_c) * 48'(tmag_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) div_used_ff <= 1'b0;
      else if (st_ff == ST_AXIS) div_used_ff <= (st_in == ST_MUL);
   end

   assign rsp_valid       = vld_ff;
   assign rsp_pitch_angle = 32'(ang_ff[0]);
   assign rsp_yaw_angle   = 32'(ang_ff[1]);
   assign rsp_roll_angle  = 32'(ang_ff[2]);
   assign rsp_run_mode    = mode_ff;
   assign rsp_sound_cue   = cue_ff;

   // The divider only finishes while the sequencer waits on it.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> st_ff == ST_DIV) else $error("divider finished out of turn");
   // No new item is taken while a result waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> !req_ready) else $error("item accepted with result pending");
   // Results come from the finishing step only.
   a_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff) |-> $past(st_ff) == ST_FIN) else $error("stray result");
endmodule
